// ----- hw/rtl/lqc_pkg.sv -----
// Shared types and constants for the link quality classifier.
package lqc_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned LevelW   = 7;
  localparam int unsigned HoldW    = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] CFG_CHANGE_DELTA = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_HIGH_LEVEL   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_LOW_LEVEL    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_LOST_HOLD    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_GOOD_HOLD    = 3'd4;

  // Register values after reset.
  localparam logic [LevelW-1:0] RST_CHANGE_DELTA = 7'd10;
  localparam logic [LevelW-1:0] RST_HIGH_LEVEL   = 7'd90;
  localparam logic [LevelW-1:0] RST_LOW_LEVEL    = 7'd10;
  localparam logic [HoldW-1:0]  RST_LOST_HOLD    = 16'd3000;
  localparam logic [HoldW-1:0]  RST_GOOD_HOLD    = 16'd5000;

  // Link classification, same encoding on the result ports.
  typedef enum logic [1:0] {
    LS_DISCONNECTED = 2'd0,
    LS_UNSTABLE     = 2'd1,
    LS_CONNECTED    = 2'd2
  } link_state_t;

  // Current configuration as seen by the classifier.
  typedef struct packed {
    logic [LevelW-1:0] change_delta;
    logic [LevelW-1:0] high_level;
    logic [LevelW-1:0] low_level;
    logic [HoldW-1:0]  lost_hold_ms;
    logic [HoldW-1:0]  good_hold_ms;
  } cfg_t;

  // One result beat.
  typedef struct packed {
    link_state_t link_state;
    logic        event_valid;
    link_state_t event_state;
  } res_t;

endpackage

// ----- hw/rtl/lqc_cfg.sv -----
// Configuration register file of the link quality classifier.
module lqc_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [lqc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [lqc_pkg::CfgDataW-1:0] cfg_data,
  output lqc_pkg::cfg_t                cfg
);
  import lqc_pkg::*;

  // Writes to an index beyond the register list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.change_delta <= RST_CHANGE_DELTA;
      cfg.high_level   <= RST_HIGH_LEVEL;
      cfg.low_level    <= RST_LOW_LEVEL;
      cfg.lost_hold_ms <= RST_LOST_HOLD;
      cfg.good_hold_ms <= RST_GOOD_HOLD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHANGE_DELTA: cfg.change_delta <= cfg_data[LevelW-1:0];
        CFG_HIGH_LEVEL:   cfg.high_level   <= cfg_data[LevelW-1:0];
        CFG_LOW_LEVEL:    cfg.low_level    <= cfg_data[LevelW-1:0];
        CFG_LOST_HOLD:    cfg.lost_hold_ms <= cfg_data[HoldW-1:0];
        CFG_GOOD_HOLD:    cfg.good_hold_ms <= cfg_data[HoldW-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/lqc_core.sv -----
// Classifier state and the per-sample update logic.
module lqc_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       fire,
  input  logic [lqc_pkg::LevelW-1:0] strength,
  input  logic [lqc_pkg::TimeW-1:0]  now_ms,
  input  logic                       player_busy,
  input  lqc_pkg::cfg_t              cfg,
  output lqc_pkg::res_t              res
);
  import lqc_pkg::*;

  logic [LevelW-1:0] recorded_strength, recorded_strength_next;
  logic [TimeW-1:0]  unstable_stamp, unstable_stamp_next;
  link_state_t       current_state, current_state_next;
  link_state_t       announced_state, announced_state_next;

  logic [LevelW-1:0] diff;
  logic              went_unstable;
  logic [TimeW-1:0]  elapsed;
  logic              lost_hit;
  logic              good_hit;
  logic              announce;

  // Instability test against the last recorded strength.
  always_comb begin
    diff = (strength >= recorded_strength) ? (strength - recorded_strength)
                                           : (recorded_strength - strength);
    went_unstable = (diff > cfg.change_delta) && (strength < cfg.high_level);
    recorded_strength_next = went_unstable ? strength : recorded_strength;
    unstable_stamp_next    = went_unstable ? now_ms : unstable_stamp;
  end

  // Hold timers run from the stamp with wrapping subtraction.
  always_comb begin
    elapsed  = now_ms - unstable_stamp_next;
    lost_hit = (strength < cfg.low_level) &&
               (elapsed > {{(TimeW-HoldW){1'b0}}, cfg.lost_hold_ms});
    good_hit = (strength > cfg.high_level) &&
               (elapsed > {{(TimeW-HoldW){1'b0}}, cfg.good_hold_ms});
  end

  // New classification; the disconnect test takes precedence.
  always_comb begin
    current_state_next = current_state;
    if (went_unstable) begin
      current_state_next = LS_UNSTABLE;
    end
    priority if (lost_hit) begin
      current_state_next = LS_DISCONNECTED;
    end else if (good_hit) begin
      current_state_next = LS_CONNECTED;
    end else begin
      current_state_next = current_state_next;
    end
  end

  // Announce a change only while the player is quiet.
  always_comb begin
    announce             = !player_busy && (current_state_next != announced_state);
    announced_state_next = announce ? current_state_next : announced_state;
    res.link_state       = current_state_next;
    res.event_valid      = announce;
    res.event_state      = announce ? current_state_next : LS_DISCONNECTED;
  end

  // State advances once per sample taken into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      recorded_strength <= '0;
      unstable_stamp    <= '0;
      current_state     <= LS_DISCONNECTED;
      announced_state   <= LS_DISCONNECTED;
    end else if (fire) begin
      recorded_strength <= recorded_strength_next;
      unstable_stamp    <= unstable_stamp_next;
      current_state     <= current_state_next;
      announced_state   <= announced_state_next;
    end
  end

  // An event always carries the state just computed.
  a_event_matches_state: assert property (@(posedge clk) disable iff (rst)
    res.event_valid |-> (res.event_state == res.link_state))
    else $error("event state differs from link state");

  // After an announcement the announced and current states agree.
  a_announce_tracks: assert property (@(posedge clk) disable iff (rst)
    (fire && res.event_valid) |=> (announced_state == current_state))
    else $error("announced state not updated");

  // A busy player leaves the announced state untouched.
  a_busy_holds: assert property (@(posedge clk) disable iff (rst)
    (fire && player_busy) |=> $stable(announced_state))
    else $error("announced state changed while busy");

  // A detected instability records the sample's strength and time.
  a_unstable_records: assert property (@(posedge clk) disable iff (rst)
    (fire && went_unstable) |=>
      (recorded_strength == $past(strength)) && (unstable_stamp == $past(now_ms)))
    else $error("instability not recorded");

endmodule

// ----- hw/rtl/link_quality_classifier.sv -----
// Top level of the link quality classifier: input register, classifier, result register.
// The block takes one sample per clock cycle while the result port is not stalled and
// returns one result beat for each sample; a sample passes through the input register
// and then the result register. The rate is set by the classifier state update, which is
// done as a sample moves from the input register to the result register, so consecutive
// samples see each other's state without a gap. A full result register that is stalled
// holds the sample behind it; the input register then stalls the sender. Configuration
// writes take effect in the next cycle.
module link_quality_classifier (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lqc_pkg::LevelW-1:0]   strength,
  input  logic [lqc_pkg::TimeW-1:0]    now_ms,
  input  logic                         player_busy,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   link_state,
  output logic                         event_valid,
  output logic [1:0]                   event_state,
  input  logic                         cfg_we,
  input  logic [lqc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [lqc_pkg::CfgDataW-1:0] cfg_data
);
  import lqc_pkg::*;

  cfg_t              cfg;
  res_t              step_res;
  res_t              out_res;
  logic              in_reg_valid;
  logic [LevelW-1:0] in_reg_strength;
  logic [TimeW-1:0]  in_reg_now_ms;
  logic              in_reg_busy;
  logic              advance;
  logic              in_take;

  lqc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Handshake: the sample moves on whenever the result register can take it.
  always_comb begin
    advance  = in_reg_valid && (!out_valid || !out_stall);
    in_stall = in_reg_valid && !advance;
    in_take  = in_valid && !in_stall;
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_take) begin
      in_reg_valid <= 1'b1;
    end else if (advance) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_reg_strength <= strength;
      in_reg_now_ms   <= now_ms;
      in_reg_busy     <= player_busy;
    end
  end

  lqc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (advance),
    .strength    (in_reg_strength),
    .now_ms      (in_reg_now_ms),
    .player_busy (in_reg_busy),
    .cfg         (cfg),
    .res         (step_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign link_state  = out_res.link_state;
  assign event_valid = out_res.event_valid;
  assign event_state = out_res.event_state;

endmodule
